// ===== rtl/fca_pkg.sv =====
// Shared types, constants and request codes for the chain allocator.
// Used by every RTL file of the block but fca_ram; depends on nothing.
package fca_pkg;

    localparam int MAX_SECTORS          = 4096;
    localparam int LINKS_PER_FAT_SECTOR = 128;
    localparam int SECTOR_BYTES         = 512;

    localparam int SEC_W      = $clog2(MAX_SECTORS);
    localparam int CNT_W      = SEC_W + 1;
    localparam int LINK_W     = 16;
    localparam int TOTAL_W    = 13;
    localparam int LEN_W      = 22;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int BYTE_SHIFT = $clog2(SECTOR_BYTES);
    localparam int NEED_W     = LEN_W + 1 - BYTE_SHIFT;
    localparam int LPF_SHIFT  = $clog2(LINKS_PER_FAT_SECTOR);
    localparam int TOTAL_X_W  = (TOTAL_W > CNT_W) ? TOTAL_W : CNT_W;

    localparam int S_TDATA_W = ((SEC_W + LEN_W + 7) / 8) * 8;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = ((SEC_W + TOTAL_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W + 2;

    // Register value after reset and the table geometry that follows from it.
    localparam int RESET_TOTAL = 4096;
    localparam int RESET_LIVE  = (RESET_TOTAL == 0 || RESET_TOTAL > MAX_SECTORS) ?
                                 MAX_SECTORS : RESET_TOTAL;
    localparam int RESET_ROOT  = 1 + (RESET_LIVE + LINKS_PER_FAT_SECTOR - 1) /
                                 LINKS_PER_FAT_SECTOR;

    localparam logic [LINK_W-1:0] MARK_FREE = 16'h0000;
    localparam logic [LINK_W-1:0] MARK_END  = 16'hFFFF;

    localparam logic [REQ_W-1:0] REQ_FORMAT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_EXTEND = 3'd3;
    localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_USED   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEC_W-1:0]    sector_out;
        logic                is_end;
        logic                is_free;
        logic [TOTAL_W-1:0]  used_sectors;
    } fca_result_t;

    typedef struct packed {
        logic [SEC_W-1:0]  raddr;
        logic              we;
        logic [SEC_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
    } fca_mem_req_t;

endpackage

// ===== rtl/fca_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fca_ctrl.sv =====
// Request sequencer: format sweep, first-fit scans, chain walk and link reads
// over the link table RAM. Depends on fca_pkg.
module fca_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [fca_pkg::TOTAL_W-1:0]        cfg_total,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [fca_pkg::REQ_W-1:0]          req_type,
    input  logic [fca_pkg::SEC_W-1:0]          req_sector,
    input  logic [fca_pkg::LEN_W-1:0]          req_len,
    output fca_pkg::fca_mem_req_t              mem,
    input  logic [fca_pkg::LINK_W-1:0]         mem_rdata,
    output logic                               res_valid,
    input  logic                               res_free,
    output fca_pkg::fca_result_t               res
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_ALLOC     = 4'd2;
    localparam logic [3:0] S_ALLOC_END = 4'd3;
    localparam logic [3:0] S_EXT       = 4'd4;
    localparam logic [3:0] S_EXT_END   = 4'd5;
    localparam logic [3:0] S_FREE      = 4'd6;
    localparam logic [3:0] S_NEXT      = 4'd7;
    localparam logic [3:0] S_USED      = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    localparam int SEC_W  = fca_pkg::SEC_W;
    localparam int CNT_W  = fca_pkg::CNT_W;
    localparam int NEED_W = fca_pkg::NEED_W;
    localparam int X_W    = fca_pkg::TOTAL_X_W;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [SEC_W-1:0]    rd_addr_reg, rd_addr_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [NEED_W-1:0]   cnt_reg, cnt_next;
    logic [SEC_W-1:0]    first_reg, first_next;
    logic [SEC_W-1:0]    prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]    steps_reg, steps_next;
    logic [CNT_W-1:0]    nfree_reg, nfree_next;
    logic [CNT_W-1:0]    live_total_reg, live_total_next;
    logic [SEC_W-1:0]    root_reg, root_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic                clr_req_reg, clr_req_next;
    fca_pkg::fca_result_t res_reg, res_next;

    logic [X_W-1:0]      t_ext;
    logic [CNT_W-1:0]    live_fmt;
    logic [X_W:0]        root_sum;
    logic [SEC_W-1:0]    root_fmt;
    logic [fca_pkg::LEN_W:0] len_round;
    logic [NEED_W-1:0]   need_req;
    logic                in_range;
    logic                issue;
    logic                hit;
    logic                over;
    logic                walk_stop;

    // Geometry for a format: a total of zero or above the table size selects the
    // full table; the root sits one past the reserved table sectors.
    assign t_ext    = X_W'(cfg_total);
    assign live_fmt = (t_ext == '0 || t_ext > X_W'(fca_pkg::MAX_SECTORS)) ?
                      CNT_W'(fca_pkg::MAX_SECTORS) : CNT_W'(t_ext);
    assign root_sum = (X_W + 1)'(live_fmt) + (X_W + 1)'(fca_pkg::LINKS_PER_FAT_SECTOR - 1);
    assign root_fmt = SEC_W'((root_sum >> fca_pkg::LPF_SHIFT) + 1'b1);

    assign len_round = {1'b0, req_len} + (fca_pkg::LEN_W + 1)'(fca_pkg::SECTOR_BYTES - 1);
    assign need_req  = (req_len == '0) ? NEED_W'(1) :
                       NEED_W'(len_round >> fca_pkg::BYTE_SHIFT);

    assign in_range = CNT_W'(req_sector) < live_total_reg;
    assign issue    = scan_addr_reg < live_total_reg;
    assign hit      = rd_pend_reg && (mem_rdata == fca_pkg::MARK_FREE);
    assign over     = !rd_pend_reg && !issue;

    // The walk ends on an end mark, a link off the table, a self link (its entry
    // has just been freed) or the step limit.
    assign walk_stop = (mem_rdata == fca_pkg::MARK_END) ||
                       (mem_rdata >= fca_pkg::LINK_W'(fca_pkg::MAX_SECTORS)) ||
                       (mem_rdata[SEC_W-1:0] == rd_addr_reg) ||
                       (CNT_W'(steps_reg + 1'b1) == CNT_W'(fca_pkg::MAX_SECTORS));

    assign req_ready = (state_reg == S_IDLE);
    assign res       = res_reg;

    always_comb begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = rd_pend_reg;
        rd_addr_next    = rd_addr_reg;
        need_next       = need_reg;
        cnt_next        = cnt_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        steps_next      = steps_reg;
        nfree_next      = nfree_reg;
        live_total_next = live_total_reg;
        root_next       = root_reg;
        sec_next        = sec_reg;
        clr_req_next    = clr_req_reg;
        res_next        = res_reg;
        res_valid       = 1'b0;
        mem             = '0;
        mem.raddr       = scan_addr_reg[SEC_W-1:0];

        // Scan states fetch one entry a cycle; the data arrives in the next cycle.
        if (state_reg == S_ALLOC || state_reg == S_EXT || state_reg == S_USED) begin
            if (issue) begin
                scan_addr_next = scan_addr_reg + 1'b1;
                rd_pend_next   = 1'b1;
                rd_addr_next   = scan_addr_reg[SEC_W-1:0];
            end else begin
                rd_pend_next = 1'b0;
            end
        end

        case (state_reg)
            S_CLEAR: begin
                mem.we         = 1'b1;
                mem.waddr      = scan_addr_reg[SEC_W-1:0];
                mem.wdata      = (scan_addr_reg <= CNT_W'(root_reg)) ?
                                 fca_pkg::MARK_END : fca_pkg::MARK_FREE;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == CNT_W'(fca_pkg::MAX_SECTORS - 1)) begin
                    state_next = clr_req_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                mem.raddr = req_sector;
                if (req_valid) begin
                    res_next       = '0;
                    rd_pend_next   = 1'b0;
                    scan_addr_next = CNT_W'(root_reg) + 1'b1;
                    have_prev_next = 1'b0;
                    cnt_next       = '0;
                    nfree_next     = '0;
                    first_next     = '0;
                    steps_next     = '0;
                    rd_addr_next   = req_sector;
                    sec_next       = req_sector;
                    need_next      = need_req;
                    case (req_type)
                        fca_pkg::REQ_FORMAT: begin
                            live_total_next = live_fmt;
                            root_next       = root_fmt;
                            scan_addr_next  = '0;
                            clr_req_next    = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        fca_pkg::REQ_ALLOC: begin
                            state_next = S_ALLOC;
                        end
                        fca_pkg::REQ_FREE, fca_pkg::REQ_EXTEND, fca_pkg::REQ_NEXT: begin
                            if (!in_range) begin
                                res_next.status = fca_pkg::STAT_RANGE;
                                state_next      = S_DONE;
                            end else if (req_type == fca_pkg::REQ_FREE) begin
                                state_next = S_FREE;
                            end else if (req_type == fca_pkg::REQ_EXTEND) begin
                                state_next = S_EXT;
                            end else begin
                                state_next = S_NEXT;
                            end
                        end
                        fca_pkg::REQ_USED: begin
                            state_next = S_USED;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (hit) begin
                    // The previous sector's link is written once its successor is known.
                    if (have_prev_reg) begin
                        mem.we    = 1'b1;
                        mem.waddr = prev_reg;
                        mem.wdata = fca_pkg::LINK_W'(rd_addr_reg);
                    end else begin
                        first_next = rd_addr_reg;
                    end
                    prev_next      = rd_addr_reg;
                    have_prev_next = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    if (NEED_W'(cnt_reg + 1'b1) == need_reg) begin
                        res_next.status = fca_pkg::STAT_OK;
                        state_next      = S_ALLOC_END;
                    end
                end else if (over) begin
                    res_next.status = fca_pkg::STAT_FULL;
                    state_next      = S_ALLOC_END;
                end
            end
            S_ALLOC_END: begin
                if (have_prev_reg) begin
                    mem.we    = 1'b1;
                    mem.waddr = prev_reg;
                    mem.wdata = fca_pkg::MARK_END;
                end
                res_next.sector_out = (res_reg.status == fca_pkg::STAT_OK) ? first_reg : '0;
                rd_pend_next        = 1'b0;
                state_next          = S_DONE;
            end
            S_EXT: begin
                if (hit) begin
                    mem.we              = 1'b1;
                    mem.waddr           = sec_reg;
                    mem.wdata           = fca_pkg::LINK_W'(rd_addr_reg);
                    prev_next           = rd_addr_reg;
                    res_next.sector_out = rd_addr_reg;
                    state_next          = S_EXT_END;
                end else if (over) begin
                    res_next.status = fca_pkg::STAT_FULL;
                    state_next      = S_DONE;
                end
            end
            S_EXT_END: begin
                mem.we       = 1'b1;
                mem.waddr    = prev_reg;
                mem.wdata    = fca_pkg::MARK_END;
                rd_pend_next = 1'b0;
                state_next   = S_DONE;
            end
            S_FREE: begin
                mem.raddr = mem_rdata[SEC_W-1:0];
                if (mem_rdata == fca_pkg::MARK_FREE) begin
                    state_next = S_DONE;
                end else begin
                    mem.we    = 1'b1;
                    mem.waddr = rd_addr_reg;
                    mem.wdata = fca_pkg::MARK_FREE;
                    if (walk_stop) begin
                        state_next = S_DONE;
                    end else begin
                        rd_addr_next = mem_rdata[SEC_W-1:0];
                        steps_next   = steps_reg + 1'b1;
                    end
                end
            end
            S_NEXT: begin
                if (mem_rdata == fca_pkg::MARK_END) begin
                    res_next.is_end = 1'b1;
                end else if (mem_rdata == fca_pkg::MARK_FREE) begin
                    res_next.is_free = 1'b1;
                end else begin
                    res_next.sector_out = mem_rdata[SEC_W-1:0];
                end
                state_next = S_DONE;
            end
            S_USED: begin
                if (hit) begin
                    nfree_next = nfree_reg + 1'b1;
                end else if (over) begin
                    res_next.used_sectors = fca_pkg::TOTAL_W'(live_total_reg - nfree_reg);
                    state_next            = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            scan_addr_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            clr_req_reg    <= 1'b0;
            live_total_reg <= CNT_W'(fca_pkg::RESET_LIVE);
            root_reg       <= SEC_W'(fca_pkg::RESET_ROOT);
        end else begin
            state_reg      <= state_next;
            scan_addr_reg  <= scan_addr_next;
            rd_pend_reg    <= rd_pend_next;
            clr_req_reg    <= clr_req_next;
            live_total_reg <= live_total_next;
            root_reg       <= root_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg   <= rd_addr_next;
        need_reg      <= need_next;
        cnt_reg       <= cnt_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        steps_reg     <= steps_next;
        nfree_reg     <= nfree_next;
        sec_reg       <= sec_next;
        res_reg       <= res_next;
    end

endmodule

// ===== rtl/fat_chain_allocator.sv =====
// A request is taken only in idle. Next link reads one entry; extend, allocate
// and used count scan the table past the root, free walks the chain, and format
// writes every table entry (one table entry a cycle).
// Throughput: one request at a time; the scans and the chain walk touch one
// RAM entry per cycle. A finished result waits in the output register while
// the next request is accepted. Reset (synchronous, active low) runs a clearing
// pass over the whole table with s_tready low; configuration is taken throughout.
module fat_chain_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fca_pkg::TOTAL_W-1:0]     cfg_wr_data,   // total_sectors
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fca_pkg::S_TDATA_W-1:0]   s_tdata,       // sector, length_bytes, zero pad
    input  logic [fca_pkg::S_TUSER_W-1:0]   s_tuser,       // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fca_pkg::M_TDATA_W-1:0]   m_tdata,       // sector_out, used_sectors, zero pad
    output logic [fca_pkg::M_TUSER_W-1:0]   m_tuser        // status, is_end, is_free
);

    localparam int SEC_W = fca_pkg::SEC_W;

    logic [fca_pkg::TOTAL_W-1:0] total_sectors_reg;
    logic                        m_valid_reg;
    fca_pkg::fca_result_t        m_res_reg;
    fca_pkg::fca_result_t        res;
    fca_pkg::fca_mem_req_t       mem;
    logic [fca_pkg::LINK_W-1:0]  mem_rdata;
    logic                        res_valid;
    logic                        res_free;

    assign res_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_sectors_reg <= fca_pkg::TOTAL_W'(fca_pkg::RESET_TOTAL);
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                total_sectors_reg <= cfg_wr_data;
            end
            if (res_valid && res_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_free) begin
            m_res_reg <= res;
        end
    end

    fca_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_total  (total_sectors_reg),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_type   (s_tuser[fca_pkg::REQ_W-1:0]),
        .req_sector (s_tdata[SEC_W-1:0]),
        .req_len    (s_tdata[SEC_W +: fca_pkg::LEN_W]),
        .mem        (mem),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_free   (res_free),
        .res        (res)
    );

    fca_ram #(
        .WIDTH (fca_pkg::LINK_W),
        .DEPTH (fca_pkg::MAX_SECTORS)
    ) u_link_ram (
        .clk   (aclk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(fca_pkg::M_TDATA_W - SEC_W - fca_pkg::TOTAL_W){1'b0}},
                       m_res_reg.used_sectors, m_res_reg.sector_out};
    assign m_tuser  = {m_res_reg.is_free, m_res_reg.is_end, m_res_reg.status};

endmodule

// ===== rtl/fca_checker.sv =====
// Port-level checks for the chain allocator, attached to the top level by bind.
// Depends on fca_pkg and fat_chain_allocator.
module fca_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fca_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [fca_pkg::M_TUSER_W-1:0]   m_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset starts the clearing pass, so no request is taken right after it.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken during clearing pass");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == fca_pkg::STAT_OK) ||
                     (m_tuser[1:0] == fca_pkg::STAT_FULL) ||
                     (m_tuser[1:0] == fca_pkg::STAT_RANGE))
        else $error("undefined status code");

    // A failed request reports no sector and no link flags.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != fca_pkg::STAT_OK) |->
            (m_tdata[fca_pkg::SEC_W-1:0] == '0) && !m_tuser[2] && !m_tuser[3])
        else $error("failed request carries a sector");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[2] && m_tuser[3]))
        else $error("end and free marks both reported");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (.*);

// ===== tb/fat_chain_check_pkg.sv =====
// Scoreboard for the chain allocator testbench: a software copy of the link
// table that predicts each reply and checks the replies as they come back.
// Depends on fca_pkg for widths, marks, request and status codes.
package fat_chain_check_pkg;

    import fca_pkg::*;

    class link_table_scoreboard;
        logic [LINK_W-1:0] links [MAX_SECTORS];
        int unsigned root_sec;
        int unsigned live_total;
        int unsigned total_reg;
        fca_result_t pending_replies [$];
        int unsigned kind_count [8];
        int unsigned checked;
        int unsigned mismatches;

        function new();
            total_reg = RESET_TOTAL;
            format_table();
        endfunction

        // The register value only takes hold here; zero or oversize means full size.
        function void format_table();
            int unsigned t;
            t = total_reg;
            if (t == 0 || t > MAX_SECTORS) t = MAX_SECTORS;
            live_total = t;
            root_sec = 1 + (t + LINKS_PER_FAT_SECTOR - 1) / LINKS_PER_FAT_SECTOR;
            for (int unsigned i = 0; i < MAX_SECTORS; i++)
                links[i] = (i <= root_sec) ? MARK_END : MARK_FREE;
        endfunction

        // Returns 0 when no free data sector lies at or after the start point.
        function int unsigned first_free_from(int unsigned start);
            if (start < root_sec + 1) start = root_sec + 1;
            for (int unsigned i = start; i < live_total; i++)
                if (links[i] == MARK_FREE) return i;
            return 0;
        endfunction

        function fca_result_t note_request(logic [REQ_W-1:0] req, logic [SEC_W-1:0] sec,
                                           logic [LEN_W-1:0] len);
            fca_result_t r;
            int unsigned need, first, prev, f, cur, steps, nfree, k;
            logic [LINK_W-1:0] nxt;
            bit done;
            r = '0;
            kind_count[req]++;
            case (req)
                REQ_FORMAT: format_table();
                REQ_ALLOC: begin
                    need = (len == 0) ? 1 : (int'(len) + SECTOR_BYTES - 1) / SECTOR_BYTES;
                    first = 0;
                    prev = 0;
                    f = root_sec + 1;
                    k = 0;
                    // Sectors linked before the disk runs out stay in the table.
                    while (k < need && r.status == STAT_OK) begin
                        f = first_free_from(f);
                        if (f == 0) begin
                            r.status = STAT_FULL;
                        end else begin
                            links[f] = MARK_END;
                            if (first == 0) first = f;
                            else links[prev] = LINK_W'(f);
                            prev = f;
                            k++;
                        end
                    end
                    r.sector_out = (r.status == STAT_OK) ? SEC_W'(first) : '0;
                end
                REQ_FREE, REQ_EXTEND, REQ_NEXT: begin
                    if (sec >= live_total) begin
                        r.status = STAT_RANGE;
                    end else if (req == REQ_FREE) begin
                        cur = 32'(sec);
                        steps = 0;
                        done = 0;
                        while (!done && steps < MAX_SECTORS && cur < MAX_SECTORS) begin
                            nxt = links[cur];
                            if (nxt == MARK_FREE) begin
                                done = 1;
                            end else begin
                                links[cur] = MARK_FREE;
                                if (nxt == MARK_END) done = 1;
                                else begin
                                    cur = 32'(nxt);
                                    steps++;
                                end
                            end
                        end
                    end else if (req == REQ_EXTEND) begin
                        f = first_free_from(root_sec + 1);
                        if (f == 0) begin
                            r.status = STAT_FULL;
                        end else begin
                            // The given entry is overwritten even if it is not a tail.
                            links[sec] = LINK_W'(f);
                            links[f] = MARK_END;
                            r.sector_out = SEC_W'(f);
                        end
                    end else begin
                        nxt = links[sec];
                        if (nxt == MARK_END) r.is_end = 1'b1;
                        else if (nxt == MARK_FREE) r.is_free = 1'b1;
                        else r.sector_out = nxt[SEC_W-1:0];
                    end
                end
                REQ_USED: begin
                    nfree = 0;
                    for (int unsigned i = root_sec + 1; i < live_total; i++)
                        if (links[i] == MARK_FREE) nfree++;
                    r.used_sectors = TOTAL_W'(live_total - nfree);
                end
                default: ;
            endcase
            pending_replies.push_back(r);
            return r;
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] reply %0d: %s expected %0h got %0h",
                         $time, checked, what, want, got);
        endtask

        task check_result(fca_result_t got);
            fca_result_t want;
            checked++;
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with no request outstanding", 0, 1);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.sector_out !== want.sector_out)
                    report_mismatch("sector_out", 32'(want.sector_out),
                                    32'(got.sector_out));
                if (got.is_end !== want.is_end)
                    report_mismatch("is_end", 32'(want.is_end), 32'(got.is_end));
                if (got.is_free !== want.is_free)
                    report_mismatch("is_free", 32'(want.is_free), 32'(got.is_free));
                if (got.used_sectors !== want.used_sectors)
                    report_mismatch("used_sectors", 32'(want.used_sectors),
                                    32'(got.used_sectors));
            end
        endtask
    endclass

endpackage

// ===== tb/fat_chain_allocator_tb.sv =====
// Top-level testbench for fat_chain_allocator: directed and random requests
// with random stalls on both streams, checked against the scoreboard class.
// Depends on fca_pkg and fat_chain_check_pkg.
module fat_chain_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fca_pkg::*;
    import fat_chain_check_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int PHASES = 7;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [TOTAL_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    link_table_scoreboard sb;
    fca_result_t          seen;
    logic [SEC_W-1:0]     chain_heads [$];
    logic                 no_gaps;
    int unsigned          cycles = 0;

    int unsigned phase_total [PHASES] = '{40, 130, 0, 300, 1, 8191, 72};
    int unsigned phase_items [PHASES] = '{20, 20, 10, 20, 4, 10, 22};

    fat_chain_allocator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (no_gaps) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) >= 18);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.status       = m_tuser[STATUS_W-1:0];
            seen.is_end       = m_tuser[STATUS_W];
            seen.is_free      = m_tuser[STATUS_W+1];
            seen.sector_out   = m_tdata[SEC_W-1:0];
            seen.used_sectors = m_tdata[SEC_W +: TOTAL_W];
            sb.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Valid stays high from one request to the next unless a gap is taken.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [SEC_W-1:0] sec,
                                input logic [LEN_W-1:0] len);
        fca_result_t reply;
        if (!no_gaps && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_TDATA_W - SEC_W - LEN_W){1'b0}}, len, sec};
        do @(posedge aclk); while (!s_tready);
        reply = sb.note_request(req, sec, len);
        if (req == REQ_ALLOC && reply.status == STAT_OK)
            chain_heads.push_back(reply.sector_out);
        else if (req == REQ_FORMAT)
            chain_heads.delete();
    endtask

    // Sampled on the falling edge so the reply monitor has already run.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.total_reg = 32'(value);
    endtask

    // Mostly well-formed traffic: frees of live chains, extends at real tails.
    task automatic send_random();
        logic [REQ_W-1:0]  req;
        logic [SEC_W-1:0]  sec;
        logic [LEN_W-1:0]  len;
        logic [LINK_W-1:0] hop;
        int unsigned       pick, steps;
        pick = $urandom_range(0, 99);
        sec  = SEC_W'($urandom_range(0, sb.live_total - 1));
        len  = LEN_W'($urandom_range(0, 2048));
        if (pick < 30) begin
            req = REQ_ALLOC;
            case ($urandom_range(0, 9))
                0: len = LEN_W'($urandom);
                1, 2: len = LEN_W'($urandom_range(0, 16384));
                default: ;
            endcase
        end else if (pick < 45) begin
            req = REQ_FREE;
            if (chain_heads.size() != 0 && $urandom_range(0, 3) != 0)
                sec = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
            else if ($urandom_range(0, 3) == 0)
                sec = SEC_W'($urandom);
        end else if (pick < 60) begin
            req = REQ_EXTEND;
            if (chain_heads.size() != 0 && $urandom_range(0, 4) < 3) begin
                sec = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
                hop = sb.links[sec];
                steps = 0;
                while (steps < MAX_SECTORS && hop != MARK_END && hop != MARK_FREE) begin
                    sec = hop[SEC_W-1:0];
                    hop = sb.links[sec];
                    steps++;
                end
            end else if ($urandom_range(0, 3) == 0) begin
                sec = SEC_W'($urandom);
            end
        end else if (pick < 82) begin
            req = REQ_NEXT;
            if ($urandom_range(0, 1)) sec = SEC_W'($urandom);
        end else if (pick < 88) begin
            req = REQ_USED;
        end else if (pick < 92) begin
            req = REQ_FORMAT;
        end else begin
            req = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
        end
        if (req != REQ_ALLOC) len = LEN_W'($urandom);
        if (req == REQ_FORMAT || req == REQ_USED) sec = SEC_W'($urandom);
        send_request(req, sec, len);
    endtask

    initial begin
        sb          = new();
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        no_gaps     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Table as left by reset: full size, root right after the reserved area.
        send_request(REQ_USED, 12'd0, 22'd0);
        send_request(REQ_NEXT, 12'd0, 22'd0);
        send_request(REQ_NEXT, 12'd4095, 22'd0);
        send_request(REQ_ALLOC, 12'd0, 22'd0);
        send_request(REQ_ALLOC, 12'd0, 22'd1);
        send_request(REQ_ALLOC, 12'd0, 22'd513);
        send_request(REQ_NEXT, 12'd36, 22'd0);
        send_request(REQ_EXTEND, 12'd37, 22'd0);
        send_request(REQ_EXTEND, 12'd36, 22'd0);
        send_request(REQ_EXTEND, 12'd4000, 22'd0);
        send_request(REQ_FREE, 12'd36, 22'd0);
        send_request(REQ_FREE, 12'd36, 22'd0);
        send_request(REQ_SPARE_LO, 12'd4095, 22'h3FFFFF);
        send_request(REQ_ALLOC, 12'd0, 22'd512);
        send_request(REQ_USED, 12'd0, 22'd0);

        // A small disk: out-of-range sectors and running out of space.
        drain_results();
        write_total(13'd40);
        send_request(REQ_FORMAT, 12'd0, 22'd0);
        send_request(REQ_NEXT, 12'd40, 22'd0);
        send_request(REQ_FREE, 12'd4095, 22'd0);
        send_request(REQ_EXTEND, 12'd40, 22'd0);
        send_request(REQ_ALLOC, 12'd0, 22'h3FFFFF);
        send_request(REQ_EXTEND, 12'd39, 22'd0);
        send_request(REQ_ALLOC, 12'd0, 22'd0);
        send_request(REQ_USED, 12'd0, 22'd0);
        send_request(REQ_FREE, 12'd3, 22'd0);
        send_request(REQ_USED, 12'd0, 22'd0);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_total(TOTAL_W'(phase_total[p]));
            no_gaps <= (p == 3);
            send_request(REQ_FORMAT, SEC_W'($urandom), LEN_W'($urandom));
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == 12) drain_results();
                send_random();
            end
        end

        drain_results();
        repeat (MAX_SECTORS + 8) @(posedge aclk);
        if (sb.pending_replies.size() != 0)
            sb.report_mismatch("replies never returned", 0, sb.pending_replies.size());

        $display("Covered %0d allocate, %0d free, %0d extend, %0d next, %0d used, %0d format",
                 sb.kind_count[REQ_ALLOC], sb.kind_count[REQ_FREE], sb.kind_count[REQ_EXTEND],
                 sb.kind_count[REQ_NEXT], sb.kind_count[REQ_USED], sb.kind_count[REQ_FORMAT]);
        $display("and %0d unused-code requests over %0d disk sizes; %0d replies, %0d bad fields.",
                 sb.kind_count[REQ_SPARE_LO] + sb.kind_count[REQ_SPARE_HI], PHASES + 2,
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
